// ----- hdl/prd_pkg.sv -----
// prd_pkg: shared types and constants for the pinhole ray direction core.
// No dependencies.
package prd_pkg;

	localparam int COMP_W  = 20;             // signed Q12.8 vector component
	localparam int VEC_W   = 3 * COMP_W;     // packed x,y,z
	localparam int DIR_W   = 16;             // signed Q1.x direction code
	localparam int NORM_MSB = 29;            // largest magnitude lands in [2^29, 2^30)
	localparam int NORM_W  = NORM_MSB + 1;
	localparam int HALF_W  = NORM_W / 2;
	localparam int LEN2_W  = 2 * NORM_W + 2;
	localparam int ROOT_W  = LEN2_W / 2;
	localparam int SQ_STEPS = LEN2_W / 2;

	typedef enum logic [1:0] {
		REG_ORIGIN = 2'd0,
		REG_RIGHT  = 2'd1,
		REG_UP     = 2'd2,
		REG_CORNER = 2'd3
	} reg_idx_t;

endpackage

// ----- hdl/pinhole_ray_direction_core.sv -----
// pinhole_ray_direction_core: pipelined primary ray generator for a pinhole camera.
// Depends on prd_pkg (hdl/prd_pkg.sv).
//
//  channel   | dir | payload (lsb first)                                   | accepted when
//  s_axis    | in  | pixel_x, pixel_y                                      | s_tvalid & s_tready
//  m_axis    | out | dir_x, dir_y, dir_z, orig_x, orig_y, orig_z, zero_len | m_tvalid & m_tready
//  apb       | in  | origin, right, up, corner at byte 0/8/16/24           | psel&penable&pwrite
//
// One ray per clock while the output register is free or being drained. The long part is the
// bit-per-stage square root (31 stages) and the bit-per-stage divider
// (DIR_FRAC_BITS+1 stages, three lanes side by side).
// The whole pipeline advances together; it halts only when the output register holds
// a ray that m_tready has not taken, so nothing is lost or repeated.
// arst_n clears all valid bits and the configuration registers.
module pinhole_ray_direction_core #(
	parameter int COORD_WIDTH   = 12,
	parameter int DIR_FRAC_BITS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pixel_x [COORD_WIDTH-1:0], pixel_y above it, zero pad to bytes
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// dir_x[15:0], dir_y[31:16], dir_z[47:32], orig_x[67:48], orig_y[87:68],
	// orig_z[107:88], zero_length[108], zero pad [111:109]
	output logic [111:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	localparam int CW  = COORD_WIDTH;
	localparam int FB  = DIR_FRAC_BITS;
	localparam int CWP = prd_pkg::COMP_W;
	localparam int PW  = CWP + CW + 1;            // one product
	localparam int SW  = CW + 23;                 // sum of two products and corner
	localparam int PSW = $clog2(SW);
	localparam int NW  = prd_pkg::NORM_W;
	localparam int HW  = prd_pkg::HALF_W;
	localparam int LW  = prd_pkg::LEN2_W;
	localparam int RW  = prd_pkg::ROOT_W;
	localparam int SQN = prd_pkg::SQ_STEPS;
	localparam int QW  = FB + 1;                  // quotient bits, q <= 2^FB
	localparam int DW  = NW + FB + 1;             // dividend bits
	localparam int DRW = RW + 1;                  // divider remainder
	localparam int XW  = (QW + 2 > 18) ? QW + 2 : 18;   // quotient wide enough for limits

	// ---------------- configuration ----------------
	logic [prd_pkg::VEC_W-1:0] origin_q, right_q, up_q, corner_q;
	logic                      cfg_wr;
	prd_pkg::reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = prd_pkg::reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			right_q  <= '0;
			up_q     <= '0;
			corner_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				prd_pkg::REG_ORIGIN: origin_q <= pwdata[prd_pkg::VEC_W-1:0];
				prd_pkg::REG_RIGHT:  right_q  <= pwdata[prd_pkg::VEC_W-1:0];
				prd_pkg::REG_UP:     up_q     <= pwdata[prd_pkg::VEC_W-1:0];
				prd_pkg::REG_CORNER: corner_q <= pwdata[prd_pkg::VEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			prd_pkg::REG_ORIGIN: prdata = {4'd0, origin_q};
			prd_pkg::REG_RIGHT:  prdata = {4'd0, right_q};
			prd_pkg::REG_UP:     prdata = {4'd0, up_q};
			prd_pkg::REG_CORNER: prdata = {4'd0, corner_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// single enable: every stage moves when the output slot is free or being drained
	logic en;
	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	logic [CW-1:0] px, py;
	assign px = s_tdata[CW-1:0];
	assign py = s_tdata[2*CW-1:CW];

	// s1: six products and the corner components
	logic                  vld_s1;
	logic signed [PW-1:0]  pr_s1 [3];
	logic signed [PW-1:0]  pu_s1 [3];
	logic signed [CWP-1:0] co_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_s1[i] <= $signed(right_q[i*CWP +: CWP]) * $signed({1'b0, px});
				pu_s1[i] <= $signed(up_q[i*CWP +: CWP]) * $signed({1'b0, py});
				co_s1[i] <= $signed(corner_q[i*CWP +: CWP]);
			end
		end
	end

	// s2: exact sum, split into sign and magnitude
	logic          vld_s2;
	logic [SW-1:0] mag_s2 [3];
	logic [2:0]    neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] s;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s = SW'(pr_s1[i]) + SW'(pu_s1[i]) + SW'(co_s1[i]);
				neg_s2[i] <= s[SW-1];
				mag_s2[i] <= s[SW-1] ? SW'(-s) : SW'(s);
			end
		end
	end

	// s3: leading one of the largest magnitude (same as of the OR of all three)
	logic           vld_s3, zero_s3;
	logic [SW-1:0]  mag_s3 [3];
	logic [2:0]     neg_s3;
	logic [PSW-1:0] pos_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		logic [SW-1:0]  orv;
		logic [PSW-1:0] p;
		if (en) begin
			orv = mag_s2[0] | mag_s2[1] | mag_s2[2];
			p = '0;
			for (int b = 0; b < SW; b++)
				if (orv[b]) p = PSW'(b);
			pos_s3  <= p;
			zero_s3 <= (orv == '0);
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
		end
	end

	// s4: common shift to put the leading one at bit 29
	logic          vld_s4, zero_s4;
	logic [NW-1:0] nm_s4 [3];
	logic [2:0]    neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (pos_s3 > PSW'(prd_pkg::NORM_MSB))
					nm_s4[i] <= NW'(mag_s3[i] >> (pos_s3 - PSW'(prd_pkg::NORM_MSB)));
				else
					nm_s4[i] <= NW'(mag_s3[i] << (PSW'(prd_pkg::NORM_MSB) - pos_s3));
			end
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
		end
	end

	// s5: squares as 15x15 partial products
	logic            vld_s5, zero_s5;
	logic [NW-1:0]   nm_s5 [3];
	logic [2:0]      neg_s5;
	logic [2*HW-1:0] hh_s5 [3], hl_s5 [3], ll_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= nm_s4[i][NW-1:HW] * nm_s4[i][NW-1:HW];
				hl_s5[i] <= nm_s4[i][NW-1:HW] * nm_s4[i][HW-1:0];
				ll_s5[i] <= nm_s4[i][HW-1:0] * nm_s4[i][HW-1:0];
			end
			nm_s5   <= nm_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	// s6: per-component squares
	logic            vld_s6, zero_s6;
	logic [NW-1:0]   nm_s6 [3];
	logic [2:0]      neg_s6;
	logic [2*NW-1:0] sq_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s6[i] <= ((2*NW)'(hh_s5[i]) << (2*HW)) + ((2*NW)'(hl_s5[i]) << (HW+1))
					+ (2*NW)'(ll_s5[i]);
			nm_s6   <= nm_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// s7: squared length
	typedef struct packed {
		logic          zero;
		logic [2:0]    neg;
		logic [NW-1:0] nm0, nm1, nm2;
		logic [LW-1:0] l2;        // remaining radicand bits, consumed from the top
		logic [RW+1:0] rem;
		logic [RW-1:0] root;
	} sqrt_stage_t;

	sqrt_stage_t sq_st [SQN+1];
	logic        sq_vld [SQN+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld[0] <= 1'b0;
		else if (en) sq_vld[0] <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_st[0].zero <= zero_s6;
			sq_st[0].neg  <= neg_s6;
			sq_st[0].nm0  <= nm_s6[0];
			sq_st[0].nm1  <= nm_s6[1];
			sq_st[0].nm2  <= nm_s6[2];
			sq_st[0].l2   <= LW'(sq_s6[0]) + LW'(sq_s6[1]) + LW'(sq_s6[2]);
			sq_st[0].rem  <= '0;
			sq_st[0].root <= '0;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld[k+1] <= 1'b0;
			else if (en) sq_vld[k+1] <= sq_vld[k];
		end

		always_ff @(posedge clk) begin
			logic [RW+3:0] tr;
			logic [RW+3:0] tt;
			if (en) begin
				tr = {sq_st[k].rem, sq_st[k].l2[LW-1:LW-2]};
				tt = (RW+4)'({sq_st[k].root, 2'b01});
				if (tr >= tt) begin
					sq_st[k+1].rem  <= (RW+2)'(tr - tt);
					sq_st[k+1].root <= {sq_st[k].root[RW-2:0], 1'b1};
				end else begin
					sq_st[k+1].rem  <= (RW+2)'(tr);
					sq_st[k+1].root <= {sq_st[k].root[RW-2:0], 1'b0};
				end
				sq_st[k+1].l2   <= {sq_st[k].l2[LW-3:0], 2'b00};
				sq_st[k+1].zero <= sq_st[k].zero;
				sq_st[k+1].neg  <= sq_st[k].neg;
				sq_st[k+1].nm0  <= sq_st[k].nm0;
				sq_st[k+1].nm1  <= sq_st[k].nm1;
				sq_st[k+1].nm2  <= sq_st[k].nm2;
			end
		end
	end

	// dividend (mag << FB) + r/2 for three lanes, one quotient bit per stage
	typedef struct packed {
		logic           zero;
		logic [2:0]     neg;
		logic [RW-1:0]  r;
		logic [DW-1:0]  n0, n1, n2;
		logic [DRW-1:0] m0, m1, m2;   // partial remainders
		logic [QW-1:0]  q0, q1, q2;
	} div_stage_t;

	div_stage_t dv_st [QW+1];
	logic       dv_vld [QW+1];
	logic [RW-1:0] root_f;
	assign root_f = sq_st[SQN].root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld[0] <= 1'b0;
		else if (en) dv_vld[0] <= sq_vld[SQN];
	end

	always_ff @(posedge clk) begin
		logic [DW-1:0] hr;
		if (en) begin
			hr = DW'(root_f >> 1);
			dv_st[0].n0   <= (DW'(sq_st[SQN].nm0) << FB) + hr;
			dv_st[0].n1   <= (DW'(sq_st[SQN].nm1) << FB) + hr;
			dv_st[0].n2   <= (DW'(sq_st[SQN].nm2) << FB) + hr;
			dv_st[0].m0   <= '0;
			dv_st[0].m1   <= '0;
			dv_st[0].m2   <= '0;
			dv_st[0].q0   <= '0;
			dv_st[0].q1   <= '0;
			dv_st[0].q2   <= '0;
			dv_st[0].r    <= root_f;
			dv_st[0].zero <= sq_st[SQN].zero;
			dv_st[0].neg  <= sq_st[SQN].neg;
		end
	end

	// the top DW-QW dividend bits are below r, so they seed the remainder in stage 0
	for (genvar k = 0; k < QW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld[k+1] <= 1'b0;
			else if (en) dv_vld[k+1] <= dv_vld[k];
		end

		always_ff @(posedge clk) begin
			logic [DRW:0]  t0, t1, t2;
			logic [DRW:0]  rr;
			logic [DW-1:0] a0, a1, a2;
			if (en) begin
				rr = (DRW+1)'(dv_st[k].r);
				if (k == 0) begin
					a0 = dv_st[k].n0 >> QW;
					a1 = dv_st[k].n1 >> QW;
					a2 = dv_st[k].n2 >> QW;
					t0 = {a0[DRW-1:0], dv_st[k].n0[QW-1]};
					t1 = {a1[DRW-1:0], dv_st[k].n1[QW-1]};
					t2 = {a2[DRW-1:0], dv_st[k].n2[QW-1]};
				end else begin
					t0 = {dv_st[k].m0, dv_st[k].n0[QW-1]};
					t1 = {dv_st[k].m1, dv_st[k].n1[QW-1]};
					t2 = {dv_st[k].m2, dv_st[k].n2[QW-1]};
				end
				dv_st[k+1].m0 <= (t0 >= rr) ? DRW'(t0 - rr) : DRW'(t0);
				dv_st[k+1].m1 <= (t1 >= rr) ? DRW'(t1 - rr) : DRW'(t1);
				dv_st[k+1].m2 <= (t2 >= rr) ? DRW'(t2 - rr) : DRW'(t2);
				dv_st[k+1].q0 <= {dv_st[k].q0[QW-2:0], t0 >= rr};
				dv_st[k+1].q1 <= {dv_st[k].q1[QW-2:0], t1 >= rr};
				dv_st[k+1].q2 <= {dv_st[k].q2[QW-2:0], t2 >= rr};
				dv_st[k+1].n0 <= {dv_st[k].n0[DW-2:0], 1'b0};
				dv_st[k+1].n1 <= {dv_st[k].n1[DW-2:0], 1'b0};
				dv_st[k+1].n2 <= {dv_st[k].n2[DW-2:0], 1'b0};
				dv_st[k+1].r    <= dv_st[k].r;
				dv_st[k+1].zero <= dv_st[k].zero;
				dv_st[k+1].neg  <= dv_st[k].neg;
			end
		end
	end

	// output register: sign, saturation, zero-length override
	logic [prd_pkg::DIR_W-1:0] dir_q [3];
	logic                      zero_q;
	logic [QW-1:0]             qf [3];

	assign qf[0] = dv_st[QW].q0;
	assign qf[1] = dv_st[QW].q1;
	assign qf[2] = dv_st[QW].q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_vld[QW];
	end

	always_ff @(posedge clk) begin
		logic [XW-1:0] qx;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				qx = XW'(qf[i]);
				if (dv_st[QW].zero)
					dir_q[i] <= '0;
				else if (dv_st[QW].neg[i])
					dir_q[i] <= (qx > XW'(32768)) ? 16'h8000 : 16'(-qx);
				else
					dir_q[i] <= (qx > XW'(32767)) ? 16'h7FFF : 16'(qx);
			end
			zero_q <= dv_st[QW].zero;
		end
	end

	// user must hold origin static while rays are in flight (not enforced); read from register
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, zero_q, origin_q, dir_q[2], dir_q[1], dir_q[0]};

	// ---------------- checks ----------------
	a_ready_follows_slot: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not track the output slot");

	a_zero_gives_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[108]) |-> (m_tdata[47:0] == 48'd0))
		else $error("zero-length ray with non-zero direction");

	a_nonzero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[108]) |-> (m_tdata[47:0] != 48'd0))
		else $error("non-degenerate ray lost its direction");

endmodule

// ----- dv/pinhole_ray_direction_core_test.sv -----
// Self-checking bench for pinhole_ray_direction_core: streams pixel requests, predicts
// each ray direction and origin in fixed point and compares every output field.
// Depends on prd_pkg and the core RTL.
`timescale 1ns / 1ps

module pinhole_ray_direction_core_test;

	localparam int LATENCY = 7 + 31 + 1 + 16 + 1;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;

	pinhole_ray_direction_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// camera vectors as seen by the predictor
	logic [prd_pkg::VEC_W-1:0] cam_vec [4];

	logic [23:0]  pixel_q [$];   // pending pixel requests
	logic [111:0] ray_q [$];     // expected rays, oldest first
	int           errors = 0;
	int           tx_gap = 0;
	int           rx_gap = 0;
	bit           hold_tx = 1'b0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [19:0] comp(logic [prd_pkg::VEC_W-1:0] v, int i);
		return v[20*i +: 20];
	endfunction

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	// work out the ray for one pixel
	function automatic logic [111:0] trace_ray(logic [23:0] pix);
		longint      sum;
		logic [63:0] mag [3];
		bit          neg [3];
		logic [63:0] peak, len2, root, q;
		logic [15:0] dir [3];
		logic [111:0] ray;
		peak = 0;
		for (int i = 0; i < 3; i++) begin
			sum = longint'(comp(cam_vec[prd_pkg::REG_RIGHT], i)) * longint'(pix[11:0])
				+ longint'(comp(cam_vec[prd_pkg::REG_UP], i)) * longint'(pix[23:12])
				+ longint'(comp(cam_vec[prd_pkg::REG_CORNER], i));
			neg[i] = sum < 0;
			mag[i] = neg[i] ? -sum : sum;
			if (mag[i] > peak) peak = mag[i];
		end
		ray = '0;
		ray[107:48] = cam_vec[prd_pkg::REG_ORIGIN];
		if (peak == 0) begin
			ray[108] = 1'b1;
			return ray;
		end
		while (peak >= (64'd1 << 30)) begin
			peak >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (peak < (64'd1 << 29)) begin
			peak <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		root = root64(len2);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 15) + (root >> 1)) / root;
			if (neg[i]) begin
				if (q > 32768) q = 32768;
				dir[i] = 16'(-q);
			end else begin
				if (q > 32767) q = 32767;
				dir[i] = q[15:0];
			end
			ray[16*i +: 16] = dir[i];
		end
		return ray;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ray_q.push_back(trace_ray(s_tdata));
			tx_gap <= gap_len();
		end
		if (!(s_tvalid && !s_tready)) begin
			if (tx_gap == 0 && !hold_tx && pixel_q.size() > 0 &&
					!(s_tvalid && s_tready && tx_gap != 0)) begin
				if (s_tvalid && s_tready && gap_len() > 2) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_q.pop_front();
				end
			end else begin
				s_tvalid <= 1'b0;
				if (tx_gap > 0 && !(s_tvalid && s_tready)) tx_gap <= tx_gap - 1;
			end
		end
	end

	// result monitor and ready stalls
	always @(posedge clk) begin
		logic [111:0] want;
		if (m_tvalid && m_tready) begin
			if (ray_q.size() == 0) begin
				$display("%0t: unexpected ray %h", $time, m_tdata);
				errors++;
			end else begin
				want = ray_q.pop_front();
				for (int f = 0; f < 3; f++)
					if (want[16*f +: 16] != m_tdata[16*f +: 16]) begin
						$display("%0t: dir[%0d] expected %h actual %h", $time, f,
							want[16*f +: 16], m_tdata[16*f +: 16]);
						errors++;
					end
				for (int f = 0; f < 3; f++)
					if (want[48+20*f +: 20] != m_tdata[48+20*f +: 20]) begin
						$display("%0t: orig[%0d] expected %h actual %h", $time, f,
							want[48+20*f +: 20], m_tdata[48+20*f +: 20]);
						errors++;
					end
				if (want[108] != m_tdata[108]) begin
					$display("%0t: zero_length expected %b actual %b", $time,
						want[108], m_tdata[108]);
					errors++;
				end
			end
		end
		if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
		end
	end

	// register write, setup then access
	task automatic reg_write(prd_pkg::reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx) << 3; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cam_vec[idx] = val[prd_pkg::VEC_W-1:0];
	endtask

	task automatic wait_drained();
		while (pixel_q.size() > 0 || s_tvalid || ray_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [19:0] rnd_comp(int mode);
		case (mode)
		0: return 20'h80000;
		1: return 20'h7FFFF;
		2: return 20'(256 * $urandom_range(0, 2)) ^ ($urandom_range(0, 1) ? 20'hFFFFF : 20'h0);
		default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rnd_vec(int mode);
		return {4'($urandom), rnd_comp(mode), rnd_comp(mode), rnd_comp(mode)};
	endfunction

	task automatic push_pix(int x, int y);
		pixel_q.push_back({12'(y), 12'(x)});
	endtask

	initial begin
		for (int i = 0; i < 4; i++) cam_vec[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset vectors: zero sum everywhere
		push_pix(0, 0);
		push_pix(4095, 4095);
		wait_drained();

		// typical camera, directed corners of the image
		reg_write(prd_pkg::REG_ORIGIN, 64'({20'h00100, 20'hFFF00, 20'h7FFFF}));
		reg_write(prd_pkg::REG_RIGHT,  64'({20'h0, 20'h0, 20'h00001}));
		reg_write(prd_pkg::REG_UP,     64'({20'h0, 20'hFFFFF, 20'h0}));
		reg_write(prd_pkg::REG_CORNER, {4'hF, 20'hFFE00, 20'h00800, 20'hFF800});
		push_pix(0, 0); push_pix(4095, 0); push_pix(0, 4095);
		push_pix(4095, 4095); push_pix(2048, 2048); push_pix(2047, 1);
		push_pix(1, 2047); push_pix(2048, 2048);
		wait_drained();

		// extremes: sums large enough to force right shifts, and cancelling sums
		reg_write(prd_pkg::REG_RIGHT,  64'({20'h80000, 20'h7FFFF, 20'h80000}));
		reg_write(prd_pkg::REG_UP,     64'({20'h80000, 20'h80000, 20'h7FFFF}));
		reg_write(prd_pkg::REG_CORNER, 64'({20'h80000, 20'h7FFFF, 20'h80000}));
		reg_write(prd_pkg::REG_ORIGIN, 64'({20'h80000, 20'h80000, 20'h80000}));
		push_pix(4095, 4095); push_pix(0, 0); push_pix(1, 0); push_pix(0, 1);
		push_pix(4095, 0);
		wait_drained();

		// pure negative axis: saturation of a component at -32768
		reg_write(prd_pkg::REG_RIGHT,  '0);
		reg_write(prd_pkg::REG_UP,     '0);
		reg_write(prd_pkg::REG_CORNER, 64'({20'h0, 20'h0, 20'hFFFFF}));
		push_pix(7, 9);
		wait_drained();
		reg_write(prd_pkg::REG_CORNER, 64'({20'h0, 20'h0, 20'h00001}));
		push_pix(3, 3);
		wait_drained();

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 4; r++)
				reg_write(prd_pkg::reg_idx_t'(r), rnd_vec($urandom_range(0, 5)));
			for (int k = 0; k < 100; k++) begin
				case ($urandom_range(0, 9))
				0: push_pix(0, $urandom_range(0, 4095));
				1: push_pix(4095, $urandom_range(0, 4095));
				2: push_pix($urandom_range(0, 15), $urandom_range(0, 15));
				default: push_pix($urandom_range(0, 4095), $urandom_range(0, 4095));
				endcase
			end
			if (ph == 3) begin
				// sender holds off until every ray is back
				while (pixel_q.size() > 50) @(posedge clk);
				hold_tx = 1'b1;
				while (s_tvalid || ray_q.size() > 0) @(posedge clk);
				hold_tx = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule
